// ===== rtl/pbm_pkg.sv =====
package pbm_pkg;

  localparam int unsigned PORT_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W = 5;
  // word index that can also hold the full map depth (2048)
  localparam int unsigned WIDX_W = 12;

  localparam logic [PORT_W-1:0] LO_BOUND_RESET = 16'd12000;
  localparam logic [PORT_W-1:0] HI_BOUND_RESET = 16'd56000;

  localparam logic REG_LO_BOUND = 1'b0;
  localparam logic REG_HI_BOUND = 1'b1;

  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NOT_RESERVED = 2'd2;

  typedef struct packed {
    logic clr_write;
    logic capture;
    logic scan_start;
    logic scan_issue;
    logic fin_scan;
    logic rel_read;
    logic fin_rel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic issue_ok;
  } sts_t;

  // lowest set bit position; caller qualifies with |v
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/port_bitmap_allocator_core.sv =====
// Port bitmap allocator: one bit per 16-bit port number, MAP_WORDS words of
// 32 bits in an internal single-port-write memory, set bit = port in use.
// Register 0 is the low bound (lo), register 1 the high bound (hi).
// A reserve request (kind 0) walks words from lo/32+1 up to but not
// including hi/32, searching each word only from bit lo%32 upward; the
// first free port is marked and returned with status 0, else
// granted_port 0 with status 1. A release request (kind 1) clears the port's
// bit (status 0) or reports it not reserved (status 2, map unchanged).
// Timing: the memory is read one word per cycle with a registered read. One
// request is in flight at a time; a finished result sits in the output
// register while the next request is taken. After reset a clearing pass
// writes every word once, during which in_stall stays high; configuration
// writes are accepted throughout and should be made only while no request
// is pending.
module port_bitmap_allocator_core #(
  parameter int unsigned MAP_WORDS = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [pbm_pkg::PORT_W-1:0] port,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pbm_pkg::PORT_W-1:0] granted_port,
  output logic [1:0]                 status,
  // configuration: 0 low bound, 1 high bound
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [pbm_pkg::PORT_W-1:0] cfg_data
);
  import pbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: clear pass, request capture, scan loop, release RMW
  pbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // bitmap memory, config registers, bit search and result register
  pbm_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .port         (port),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .granted_port (granted_port),
    .status       (status)
  );

endmodule

// ===== rtl/pbm_ctrl.sv =====
module pbm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  output logic          out_valid,
  input  logic          out_stall,
  output pbm_pkg::cmd_t cmd,
  input  pbm_pkg::sts_t sts
);
  import pbm_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_REL_RD  = 5'b01000,
    ST_REL_CHK = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   in_xfer;
  logic   load_result;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign load_result = cmd.fin_scan || cmd.fin_rel;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.capture = 1'b1;
          if (kind == KIND_RESERVE) begin
            cmd.scan_start = 1'b1;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_REL_RD;
          end
        end
      end
      ST_SCAN: begin
        // done on a hit or when no word is left; hold if result slot is full
        if (sts.hit || !sts.issue_ok) begin
          if (out_free) begin
            cmd.fin_scan = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      ST_REL_RD: begin
        cmd.rel_read = 1'b1;
        state_next = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (out_free) begin
          cmd.fin_rel = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (load_result) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_result |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken transfer");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !load_result))
    else $error("result during clearing pass");

  a_issue_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |=> !cmd.fin_rel && !cmd.capture)
    else $error("scan issue not followed by scan or finish");
`endif

endmodule

// ===== rtl/pbm_datapath.sv =====
module pbm_datapath #(
  parameter int unsigned MAP_WORDS = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pbm_pkg::cmd_t                cmd,
  output pbm_pkg::sts_t                sts,
  input  logic [pbm_pkg::PORT_W-1:0]   port,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [pbm_pkg::PORT_W-1:0]   cfg_data,
  output logic [pbm_pkg::PORT_W-1:0]   granted_port,
  output logic [1:0]                   status
);
  import pbm_pkg::*;

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [WIDX_W-1:0] MAP_DEPTH = WIDX_W'(MAP_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  logic [WORD_W-1:0] mem [0:MAP_WORDS-1];
  logic [WORD_W-1:0] rd_data;

  logic [PORT_W-1:0] low_q, high_q;
  logic [PORT_W-1:0] req_port;
  logic [AW-1:0]     clr_addr;
  logic [WIDX_W-1:0] scan_w;
  logic [WIDX_W-1:0] rd_w;
  logic              tag_vld;

  logic [WIDX_W-1:0] start_word, high_word, end_word, req_word;
  logic [WORD_W-1:0] free_mask;
  logic [BIT_W-1:0]  hit_pos;
  logic [PORT_W-1:0] candidate;
  logic              guard;
  logic              rel_in_map, rel_set;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign start_word = {1'b0, low_q[PORT_W-1:BIT_W]} + WIDX_W'(1);
  assign high_word  = {1'b0, high_q[PORT_W-1:BIT_W]};
  assign end_word   = (high_word > MAP_DEPTH) ? MAP_DEPTH : high_word;
  assign req_word   = {1'b0, req_port[PORT_W-1:BIT_W]};

  assign free_mask = ~rd_data & ({WORD_W{1'b1}} << low_q[BIT_W-1:0]);
  assign hit_pos   = first_set(free_mask);
  assign candidate = {rd_w[PORT_W-BIT_W-1:0], hit_pos};
  assign guard     = (candidate >= high_q);

  assign rel_in_map = (req_word < MAP_DEPTH);
  assign rel_set    = rel_in_map && rd_data[req_port[BIT_W-1:0]];

  assign sts.clr_last = (clr_addr == LAST_ADDR);
  assign sts.hit      = tag_vld && (|free_mask);
  assign sts.issue_ok = (scan_w < end_word);

  always_comb begin
    rd_en   = cmd.scan_issue || cmd.rel_read;
    rd_addr = cmd.rel_read ? req_word[AW-1:0] : scan_w[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clr_write) begin
      wr_en = 1'b1;
    end else if (cmd.fin_scan) begin
      wr_en   = sts.hit && !guard;
      wr_addr = rd_w[AW-1:0];
      wr_data = rd_data | (WORD_W'(1) << hit_pos);
    end else if (cmd.fin_rel) begin
      wr_en   = rel_set;
      wr_addr = req_word[AW-1:0];
      wr_data = rd_data & ~(WORD_W'(1) << req_port[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_q    <= LO_BOUND_RESET;
      high_q   <= HI_BOUND_RESET;
      clr_addr <= '0;
      tag_vld  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LO_BOUND: low_q  <= cfg_data;
          REG_HI_BOUND: high_q <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_write) clr_addr <= clr_addr + AW'(1);
      if (cmd.scan_start || cmd.fin_scan) tag_vld <= 1'b0;
      else if (cmd.scan_issue) tag_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_port <= port;
    if (cmd.scan_start) scan_w <= start_word;
    else if (cmd.scan_issue) scan_w <= scan_w + WIDX_W'(1);
    if (cmd.scan_issue) rd_w <= scan_w;
    if (cmd.fin_scan) begin
      if (sts.hit && !guard) begin
        granted_port <= candidate;
        status       <= STATUS_OK;
      end else begin
        granted_port <= '0;
        status       <= STATUS_EXHAUSTED;
      end
    end else if (cmd.fin_rel) begin
      granted_port <= '0;
      status       <= rel_set ? STATUS_OK : STATUS_NOT_RESERVED;
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import pbm_pkg::*;

  localparam int MAP_DEPTH = 2048;
  // Longest legal stretch without a transfer: the clearing pass after reset,
  // a reserve that walks the whole map, and the long receiver hold-off. The
  // limit is several times that.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 75;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [PORT_W-1:0] granted;
    logic [1:0]        code;
  } grant_t;

  typedef enum bit {ROW_ASK, ROW_TUNE} row_kind_t;

  // one line of the directed script: a request, or a register update
  typedef struct {
    row_kind_t         what;
    logic              req_kind;
    logic [PORT_W-1:0] req_port;
    bit                typed;
    grant_t            want;
    bit                set_low;
    bit                set_high;
    logic [PORT_W-1:0] new_low;
    logic [PORT_W-1:0] new_high;
  } row_t;

  // travels with each offered request so a hand-typed result can replace
  // the predicted one when the request transfers
  typedef struct {
    bit     typed;
    grant_t want;
  } note_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              kind = KIND_RESERVE;
  logic [PORT_W-1:0] port = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PORT_W-1:0] granted_port;
  logic [1:0]        status;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = REG_LO_BOUND;
  logic [PORT_W-1:0] cfg_data = '0;

  // predictor state: occupancy map and its own copy of the registers
  bit [WORD_W-1:0]   held_map [MAP_DEPTH];
  logic [PORT_W-1:0] lo_port = LO_BOUND_RESET;
  logic [PORT_W-1:0] hi_port = HI_BOUND_RESET;
  logic [PORT_W-1:0] held_ports [$];   // ports the predictor has out, for release targets

  grant_t due_grants [$];              // expected results, oldest first
  note_t  offer_notes [$];
  int     errors = 0;
  int     idle_run = 0;

  // idling knobs, set per phase by the stimulus process
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_pcts [3] = '{0, 15, 50};

  port_bitmap_allocator_core #(.MAP_WORDS(MAP_DEPTH)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor. Reserve walks words low/32+1 .. high/32-1, each only from bit
  // low%32 upward (so the low word itself and low bit positions are never
  // handed out). Release clears a held bit or reports it not reserved.
  function automatic grant_t grant_or_free(input logic k, input logic [PORT_W-1:0] p);
    grant_t      r;
    int unsigned first_w, last_w, w, b, cand;
    bit          found;
    r.granted = '0;
    r.code = STATUS_EXHAUSTED;
    found = 1'b0;
    if (k == KIND_RESERVE) begin
      first_w = lo_port / WORD_W + 1;
      last_w = hi_port / WORD_W;
      if (last_w > MAP_DEPTH) last_w = MAP_DEPTH;
      for (w = first_w; w < last_w && !found; w++) begin
        for (b = lo_port % WORD_W; b < WORD_W && !found; b++) begin
          if (!held_map[w][b]) begin
            found = 1'b1;
            cand = w * WORD_W + b;
            // bound guard; the word range already keeps cand below high
            if (cand < hi_port) begin
              held_map[w][b] = 1'b1;
              held_ports.push_back(PORT_W'(cand));
              r.granted = PORT_W'(cand);
              r.code = STATUS_OK;
            end
          end
        end
      end
    end else begin
      w = p / WORD_W;
      b = p % WORD_W;
      r.code = STATUS_NOT_RESERVED;
      if (w < MAP_DEPTH && held_map[w][b]) begin
        held_map[w][b] = 1'b0;
        r.code = STATUS_OK;
        for (int i = 0; i < held_ports.size(); i++) begin
          if (held_ports[i] == p) begin
            held_ports.delete(i);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic row_t ask(input logic k, input logic [PORT_W-1:0] p, input bit typed,
                               input logic [PORT_W-1:0] g, input logic [1:0] s);
    row_t r;
    r.what = ROW_ASK;
    r.req_kind = k;
    r.req_port = p;
    r.typed = typed;
    r.want.granted = g;
    r.want.code = s;
    r.set_low = 1'b0;
    r.set_high = 1'b0;
    r.new_low = '0;
    r.new_high = '0;
    return r;
  endfunction

  function automatic row_t tune(input bit wl, input logic [PORT_W-1:0] lo,
                                input bit wh, input logic [PORT_W-1:0] hi);
    row_t r;
    r = ask(KIND_RESERVE, '0, 1'b0, '0, STATUS_OK);
    r.what = ROW_TUNE;
    r.set_low = wl;
    r.set_high = wh;
    r.new_low = lo;
    r.new_high = hi;
    return r;
  endfunction

  // Offer one request, with an optional idle burst in front; returns at the
  // edge where it transfers and leaves valid high for the next caller.
  task automatic offer(input logic k, input logic [PORT_W-1:0] p, input bit typed,
                       input grant_t want);
    note_t note;
    int    gap;
    if (!quiet && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(11, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    offer_notes.push_back(note);
    in_valid <= 1'b1;
    kind <= k;
    port <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Register writes happen only once every outstanding result is back.
  task automatic retune(input bit wl, input logic [PORT_W-1:0] lo,
                        input bit wh, input logic [PORT_W-1:0] hi);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_grants.size() != 0) @(posedge clk);
    if (wl) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_LO_BOUND;
      cfg_data <= lo;
      @(posedge clk);
      lo_port = lo;
    end
    if (wh) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_HI_BOUND;
      cfg_data <= hi;
      @(posedge clk);
      hi_port = hi;
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Scoreboard: check the result transfer against the oldest expectation,
  // then predict for a request transfer at the same edge. Signals are read
  // right at the edge, before any of this step's updates land.
  always @(posedge clk) begin : scoreboard
    grant_t exp_r, pred;
    note_t  note;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_grants.size() == 0) begin
          $error("result with nothing expected: granted_port %0d status %0d",
                 granted_port, status);
          errors++;
        end else begin
          exp_r = due_grants.pop_front();
          if (granted_port !== exp_r.granted) begin
            $error("granted_port: expected %0d, got %0d", exp_r.granted, granted_port);
            errors++;
          end
          if (status !== exp_r.code) begin
            $error("status: expected %0d, got %0d", exp_r.code, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = grant_or_free(kind, port);
        note = offer_notes.pop_front();
        due_grants.push_back(note.typed ? note.want : pred);
      end
    end
  end

  // watchdog: cycles in a row with neither channel transferring
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Result side: random stall bursts, plus one long hold-off that backs
  // the block up into its request channel.
  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(99) < rx_idle_pct) begin
        span = $urandom_range(11, 1);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    row_t              script [$];
    row_t              rw;
    grant_t            none;
    logic [PORT_W-1:0] lo, hi;
    int                sel, span;
    none = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset range 12000..56000: 12000 sits at bit 0 of its
    // word, and that word is skipped, so the first grant is 12032.
    script.push_back(ask(KIND_RESERVE, 16'hFFFF, 1'b1, 16'd12032, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd12033, STATUS_OK));
    script.push_back(ask(KIND_RELEASE, 16'd12032, 1'b1, 16'd0, STATUS_OK));
    // double release, never-held ports at both ends
    script.push_back(ask(KIND_RELEASE, 16'd12032, 1'b1, 16'd0, STATUS_NOT_RESERVED));
    script.push_back(ask(KIND_RELEASE, 16'h0000, 1'b1, 16'd0, STATUS_NOT_RESERVED));
    script.push_back(ask(KIND_RELEASE, 16'hFFFF, 1'b1, 16'd0, STATUS_NOT_RESERVED));
    // freed port comes back first
    script.push_back(ask(KIND_RESERVE, 16'h5555, 1'b1, 16'd12032, STATUS_OK));
    // empty word range: start word past end word
    script.push_back(tune(1'b1, 16'hFFFF, 1'b0, '0));
    script.push_back(ask(KIND_RESERVE, 16'hAAAA, 1'b1, 16'd0, STATUS_EXHAUSTED));
    script.push_back(tune(1'b0, '0, 1'b1, 16'hFFFF));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd0, STATUS_EXHAUSTED));
    // widest range: words 1..2046
    script.push_back(tune(1'b1, 16'h0000, 1'b0, '0));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd32, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd33, STATUS_OK));
    script.push_back(ask(KIND_RELEASE, 16'd32, 1'b1, 16'd0, STATUS_OK));
    // start bit 31: only ports 127 and 159 reachable, the rest of words 3/4
    // stays free but unreachable
    script.push_back(tune(1'b1, 16'd95, 1'b1, 16'd160));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd127, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd159, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd0, STATUS_EXHAUSTED));
    script.push_back(ask(KIND_RELEASE, 16'd127, 1'b1, 16'd0, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'hFFFF, 1'b0, 16'd0, STATUS_OK));
    script.push_back(ask(KIND_RELEASE, 16'd159, 1'b0, 16'd0, STATUS_OK));
    // both registers at zero
    script.push_back(tune(1'b1, 16'h0000, 1'b1, 16'h0000));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd0, STATUS_EXHAUSTED));
    script.push_back(tune(1'b0, '0, 1'b1, 16'd64));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b1, 16'd32, STATUS_OK));
    script.push_back(ask(KIND_RESERVE, 16'h0000, 1'b0, 16'd0, STATUS_OK));
    script.push_back(ask(KIND_RELEASE, 16'd33, 1'b0, 16'd0, STATUS_OK));
    foreach (script[i]) begin
      rw = script[i];
      if (rw.what == ROW_TUNE) retune(rw.set_low, rw.new_low, rw.set_high, rw.new_high);
      else offer(rw.req_kind, rw.req_port, rw.typed, rw.want);
    end

    // Random part: one register setting per phase, then a request mix that
    // is mostly reserves and releases of held ports, with stray releases.
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(4))
        0: begin
          lo = LO_BOUND_RESET;
          hi = HI_BOUND_RESET;
        end
        1: begin
          // narrow window, runs dry quickly
          lo = PORT_W'($urandom);
          span = int'(lo) + int'($urandom_range(400, 64));
          hi = (span > 65535) ? '1 : PORT_W'(span);
        end
        2: begin
          lo = PORT_W'($urandom_range(2000));
          hi = PORT_W'($urandom_range(65535, 60000));
        end
        3: begin
          lo = PORT_W'($urandom);
          hi = PORT_W'($urandom);
        end
        default: begin
          lo = $urandom_range(1) ? '1 : ($urandom_range(1) ? '0 : 16'd31);
          hi = $urandom_range(1) ? '1 : 16'd64;
        end
      endcase
      retune(1'b1, lo, 1'b1, hi);
      tx_idle_pct = idle_pcts[$urandom_range(2)];
      rx_idle_pct = idle_pcts[$urandom_range(2)];
      quiet = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) hold_go = 1'b1;
        sel = $urandom_range(99);
        if (sel < 55) begin
          offer(KIND_RESERVE, PORT_W'($urandom), 1'b0, none);
        end else if (sel < 85 && held_ports.size() > 0) begin
          offer(KIND_RELEASE, held_ports[$urandom_range(held_ports.size() - 1)], 1'b0, none);
        end else begin
          offer(KIND_RELEASE, PORT_W'($urandom), 1'b0, none);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_grants.size() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== port_bitmap_allocator_core.f =====
rtl/pbm_pkg.sv
rtl/pbm_ctrl.sv
rtl/pbm_datapath.sv
rtl/port_bitmap_allocator_core.sv
tb/tb.sv
